>>> hw/rtl/bbpd_pkg.sv
// shared types, constants and helper functions of the boundary pixel detector
package bbpd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CFG_W  = 11;   // width of a size register
  localparam int PIX_W  = 8;
  localparam int POS_W  = 10;   // reported row and column width
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MAXD_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int SIZE_W = ((MAXD_W + 1) > CFG_W) ? (MAXD_W + 1) : CFG_W;
  localparam int IDX_W  = 1;

  localparam logic [PIX_W-1:0] FG_VALUE = PIX_W'(255);

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_ZERO  = 2'd1,
    CLS_FG    = 2'd2
  } cls_t;

  // line store request, one per advancing word
  typedef struct packed {
    logic             step;
    logic             wr;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] n1;
    logic [COL_W-1:0] n2;
    cls_t             ncls;
  } lb_req_t;

  // neighbourhood seen by the current word
  typedef struct packed {
    cls_t cur;
    cls_t nxt;
    logic up_zero;
  } lb_rsp_t;

  function automatic cls_t classify(logic [PIX_W-1:0] p);
    cls_t c;
    c = CLS_OTHER;
    if (p == '0) c = CLS_ZERO;
    else if (p == FG_VALUE) c = CLS_FG;
    return c;
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(logic [CFG_W-1:0] v,
                                                   logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = SIZE_W'(v);
    if (v == '0) r = SIZE_W'(1);
    else if (r > maxv) r = maxv;
    return r;
  endfunction

endpackage

>>> hw/rtl/bbpd_if.sv
// valid/ready stream interfaces for pixel words and result words
interface bbpd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [bbpd_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output op, output pixel, input ready);
  modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface bbpd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        edge_res;
  logic [bbpd_pkg::POS_W-1:0]  col;
  logic [bbpd_pkg::POS_W-1:0]  row;
  logic                        end_of_frame;

  modport source (output valid, output edge_res, output col, output row,
                  output end_of_frame, input ready);
  modport sink   (input valid, input edge_res, input col, input row,
                  input end_of_frame, output ready);
endinterface

>>> hw/rtl/bbpd_ram.sv
// generic simple dual port ram with registered read
module bbpd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/bbpd_line_buf.sv
// two line stores with read-ahead and same-entry forwarding
module bbpd_line_buf (
  input  logic              clk,
  input  bbpd_pkg::lb_req_t req,
  output bbpd_pkg::lb_rsp_t rsp
);

  logic [1:0]     cram_q;
  logic           oram_q;
  logic           cfwd_v;
  bbpd_pkg::cls_t cfwd_d;
  logic           ofwd_v;
  logic           ofwd_d;
  bbpd_pkg::cls_t cur;
  bbpd_pkg::cls_t ahead;
  logic           older;
  logic           we;
  logic           cur_zero;

  assign we       = req.step && req.wr;
  assign ahead    = cfwd_v ? cfwd_d : bbpd_pkg::cls_t'(cram_q);
  assign older    = ofwd_v ? ofwd_d : oram_q;
  assign cur_zero = (cur == bbpd_pkg::CLS_ZERO);

  // class of the row under test, read two columns ahead
  bbpd_ram #(.WIDTH(2), .DEPTH(bbpd_pkg::MAX_WIDTH)) u_center (
    .clk   (clk),
    .we    (we),
    .waddr (req.col),
    .wdata (req.ncls),
    .re    (req.step),
    .raddr (req.n2),
    .rdata (cram_q)
  );

  // zero flags of the row above, read one column ahead
  bbpd_ram #(.WIDTH(1), .DEPTH(bbpd_pkg::MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (we),
    .waddr (req.col),
    .wdata (cur_zero),
    .re    (req.step),
    .raddr (req.n1),
    .rdata (oram_q)
  );

  always_ff @(posedge clk) begin
    if (req.step) begin
      cfwd_v <= req.wr && (req.n2 == req.col);
      cfwd_d <= req.ncls;
      ofwd_v <= req.wr && (req.n1 == req.col);
      ofwd_d <= cur_zero;
      cur    <= (req.wr && (req.n1 == req.col)) ? req.ncls : ahead;
    end
  end

  assign rsp.cur     = cur;
  assign rsp.nxt     = ahead;
  assign rsp.up_zero = older;

endmodule

>>> hw/rtl/binary_boundary_pixel_detect.sv
// top level of the 4-neighbour binary boundary pixel detector
// Takes one word per clock while the result register is not stalled, pixels
// of a frame in raster order, and reports whether each pixel is a boundary
// pixel: value 255 with an up, down, left or right neighbour inside the frame
// that is exactly 0. From the second row on, each pixel word yields the
// result for the pixel directly above it; after the last pixel the source
// sends frame_width flush words, which report the last row, the final one
// with end_of_frame set. Words that do not fit the current phase (a flush
// outside the flush phase, a pixel inside it) are dropped without a result.
// Throughput, one word per cycle when unstalled, is set by the two line stores
// (row classes and upper zero flags), each one read port and one write port,
// read two and one columns ahead so the read data is ready when the word
// arrives. Line store contents are undefined after reset; no clearing pass is
// run and the first frame may start at once. Sizes of 0 act as 1 and sizes
// above the maximum act as the maximum; change them only between frames.
module binary_boundary_pixel_detect (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bbpd_pkg::IDX_W-1:0]  cfg_idx,
  input  logic [bbpd_pkg::CFG_W-1:0]  cfg_data,
  bbpd_in_if.sink                     pix_in,
  bbpd_out_if.source                  res_out
);

  localparam int COL_W  = bbpd_pkg::COL_W;
  localparam int ROW_W  = bbpd_pkg::ROW_W;
  localparam int SIZE_W = bbpd_pkg::SIZE_W;

  // configuration
  logic [bbpd_pkg::CFG_W-1:0] frame_width;
  logic [bbpd_pkg::CFG_W-1:0] frame_height;

  // scan position and phase
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic             flushing;
  bbpd_pkg::cls_t   left_class;

  // result register
  logic                       out_valid;
  logic                       out_edge;
  logic [bbpd_pkg::POS_W-1:0] out_col;
  logic [bbpd_pkg::POS_W-1:0] out_row;
  logic                       out_eof;

  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [SIZE_W-1:0] c_plus;
  logic [SIZE_W-1:0] n1_plus;
  logic [SIZE_W-1:0] r_plus;
  logic              last_col;
  logic              last_row;
  logic [COL_W-1:0]  n1;
  logic [COL_W-1:0]  n2;
  logic              fire;
  logic              is_flush;
  logic              pix_act;
  logic              flush_act;
  logic              res_gen;
  bbpd_pkg::cls_t    ncls;
  logic              up_ok;
  logic              up_hit;
  logic              down_hit;
  logic              left_hit;
  logic              right_hit;
  logic              verdict;
  logic [ROW_W-1:0]  res_row;

  bbpd_pkg::lb_req_t lb_req;
  bbpd_pkg::lb_rsp_t lb_rsp;

  // effective sizes
  assign w_eff = bbpd_pkg::clamp_size(frame_width, SIZE_W'(bbpd_pkg::MAX_WIDTH));
  assign h_eff = bbpd_pkg::clamp_size(frame_height, SIZE_W'(bbpd_pkg::MAX_HEIGHT));

  // next column and the one after, wrapping at the row end
  assign c_plus   = SIZE_W'(col_count) + SIZE_W'(1);
  assign last_col = (c_plus >= w_eff);
  assign n1       = last_col ? '0 : COL_W'(c_plus);
  assign n1_plus  = SIZE_W'(n1) + SIZE_W'(1);
  assign n2       = (n1_plus >= w_eff) ? '0 : COL_W'(n1_plus);
  assign r_plus   = SIZE_W'(row_count) + SIZE_W'(1);
  assign last_row = (r_plus >= h_eff);

  // handshake: the result register frees as it drains
  assign pix_in.ready = !out_valid || res_out.ready;
  assign fire         = pix_in.valid && pix_in.ready;
  assign is_flush     = (bbpd_pkg::op_t'(pix_in.op) == bbpd_pkg::OP_FLUSH);
  assign pix_act      = fire && !is_flush && !flushing;
  assign flush_act    = fire && is_flush && flushing;
  assign res_gen      = flush_act || (pix_act && (row_count != '0));

  assign ncls = bbpd_pkg::classify(pix_in.pixel);

  assign lb_req.step = pix_act || flush_act;
  assign lb_req.wr   = pix_act;
  assign lb_req.col  = col_count;
  assign lb_req.n1   = n1;
  assign lb_req.n2   = n2;
  assign lb_req.ncls = ncls;

  bbpd_line_buf u_line_buf (
    .clk (clk),
    .req (lb_req),
    .rsp (lb_rsp)
  );

  // neighbourhood test for the reported pixel
  assign up_ok     = flushing ? (row_count != '0) : (row_count >= ROW_W'(2));
  assign up_hit    = up_ok && lb_rsp.up_zero;
  assign down_hit  = !flushing && (ncls == bbpd_pkg::CLS_ZERO);
  assign left_hit  = (col_count != '0) && (left_class == bbpd_pkg::CLS_ZERO);
  assign right_hit = !last_col && (lb_rsp.nxt == bbpd_pkg::CLS_ZERO);
  assign verdict   = (lb_rsp.cur == bbpd_pkg::CLS_FG) &&
                     (up_hit || down_hit || left_hit || right_hit);
  // pixel words report the row above, flush words the last row itself
  assign res_row   = flushing ? row_count : (row_count - ROW_W'(1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bbpd_pkg::CFG_W'(bbpd_pkg::MAX_WIDTH);
      frame_height <= bbpd_pkg::CFG_W'(bbpd_pkg::MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (bbpd_pkg::reg_idx_t'(cfg_idx))
        bbpd_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        bbpd_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan counters and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      flushing   <= 1'b0;
      left_class <= bbpd_pkg::CLS_OTHER;
    end else if (pix_act) begin
      left_class <= lb_rsp.cur;
      if (last_col) begin
        col_count <= '0;
        if (last_row) flushing <= 1'b1;
        else row_count <= ROW_W'(r_plus);
      end else begin
        col_count <= COL_W'(c_plus);
      end
    end else if (flush_act) begin
      if (last_col) begin
        col_count  <= '0;
        row_count  <= '0;
        flushing   <= 1'b0;
        left_class <= bbpd_pkg::CLS_OTHER;
      end else begin
        col_count  <= COL_W'(c_plus);
        left_class <= lb_rsp.cur;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_gen) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_gen) begin
      out_edge <= verdict;
      out_col  <= bbpd_pkg::POS_W'(col_count);
      out_row  <= bbpd_pkg::POS_W'(res_row);
      out_eof  <= flushing && last_col;
    end
  end

  assign res_out.valid        = out_valid;
  assign res_out.edge_res     = out_edge;
  assign res_out.col          = out_col;
  assign res_out.row          = out_row;
  assign res_out.end_of_frame = out_eof;

  // the last flush word closes the frame and rewinds the scan
  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    (flush_act && last_col) |=> (!flushing && col_count == '0 && row_count == '0))
    else $error("frame did not close on last flush word");

  // every word that causes a result shows it next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    res_gen |=> res_out.valid)
    else $error("result word not presented");

  // a stalled result blocks intake
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && !res_out.ready) |-> !pix_in.ready)
    else $error("word accepted while result register is stalled");

  // end of frame is only flagged on flush results
  a_eof_flush: assert property (@(posedge clk) disable iff (rst)
    (res_gen && !flush_act) |=> !res_out.end_of_frame)
    else $error("end of frame on a pixel-phase result");

endmodule
